// File: sv/hsfr_pkg.sv
// ----------------------------------------------------------------------------
// hsfr_pkg
// Shared types, constants and the byte-wise CRC-16/MODBUS step of the serial
// frame receiver.
// ----------------------------------------------------------------------------
package hsfr_pkg;

  localparam int unsigned BufferDepthDef = 64;
  localparam int unsigned MaxMarkLenDef  = 4;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 3;
  localparam int unsigned PatW     = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned HistLen  = 4;
  localparam int unsigned CrcW     = 16;

  typedef enum logic [1:0] {
    EvReady    = 2'd0,
    EvOverflow = 2'd1,
    EvByte     = 2'd2,
    EvEmpty    = 2'd3
  } event_e;

  localparam logic [CfgIdxW-1:0] CfgHeadLength  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeadPattern = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTailLength  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTailPattern = 2'd3;

  localparam logic [ByteW-1:0] PlainTailByte = 8'hFF;
  localparam logic [ByteW-1:0] CrcTailFirst  = 8'h01;
  localparam logic [ByteW-1:0] CrcTailRest   = 8'hFE;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  function automatic logic [ByteW-1:0] pat_byte(input logic [PatW-1:0] pat,
                                                input logic [1:0] idx);
    return pat[8*idx +: 8];
  endfunction

  function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0] crc_in,
                                                 input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/hsfr_if.sv
// ----------------------------------------------------------------------------
// hsfr_if
// Valid/ready channels of the serial frame receiver: received bytes in,
// result transactions out.
// ----------------------------------------------------------------------------
interface hsfr_byte_if;
  import hsfr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface hsfr_result_if;
  import hsfr_pkg::*;

  logic             valid;
  logic             ready;
  event_e           event_res;
  logic [ByteW-1:0] payload_byte;
  logic             last;

  modport source (output valid, output event_res, output payload_byte, output last,
                  input ready);
  modport sink   (input valid, input event_res, input payload_byte, input last,
                  output ready);
endinterface

// File: sv/hsfr_frame_store.sv
// ----------------------------------------------------------------------------
// hsfr_frame_store
// Frame buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hsfr_frame_store #(
  parameter int unsigned Depth = hsfr_pkg::BufferDepthDef
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [hsfr_pkg::ByteW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [hsfr_pkg::ByteW-1:0] rdata_o
);

  logic [hsfr_pkg::ByteW-1:0] mem [Depth];
  logic [hsfr_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/hmi_serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// hmi_serial_frame_receiver
// Byte-serial deframer: header match, frame buffering, tail detection
// (FF FF FF, 01 FE FE FE with CRC-16/MODBUS, configurable tail).
// ----------------------------------------------------------------------------
// Usage:
//   in_if   carries one received byte per transaction.
//   out_if  carries results: ready, overflow, payload byte, empty frame;
//           last marks the final transaction of a burst.
//   cfg_*   writes header/tail length and pattern registers, one per cycle.
// Timing:
//   A byte is accepted, then processed into the frame store.
//   A single event is loaded into the output register once it is free.
//   A payload burst reads each byte from the store, then loads it while
//   the receiver is ready; input stays stalled until the burst is handed off.
//   The output register lets the next byte in while the last result waits.
// Reset:
//   Mode returns to init, fill count and registers clear; the first byte
//   after reset only raises the ready event. Frame store contents are kept.
// Stall:
//   A stalled receiver holds the output register and stops the burst
//   sequencer, which in turn keeps in_if.ready low.
// ----------------------------------------------------------------------------
module hmi_serial_frame_receiver #(
  parameter int unsigned BufferDepth = hsfr_pkg::BufferDepthDef,
  parameter int unsigned MaxMarkLen  = hsfr_pkg::MaxMarkLenDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hsfr_byte_if.sink                     in_if,
  hsfr_result_if.source                 out_if,
  input  logic                          cfg_we_i,
  input  logic [hsfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hsfr_pkg::CfgDataW-1:0] cfg_data_i
);
  import hsfr_pkg::*;

  localparam int unsigned AddrW = $clog2(BufferDepth);
  localparam int unsigned FillW = $clog2(BufferDepth + 1);

  typedef enum logic [2:0] {
    ModeInit  = 3'd0,
    ModeIdle  = 3'd1,
    ModeHead  = 3'd2,
    ModeRcv   = 3'd3,
    ModeError = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    StIn,
    StProc,
    StRead,
    StOut,
    StEvt
  } state_e;

  logic [LenW-1:0] head_len_q, tail_len_q;
  logic [PatW-1:0] head_pat_q, tail_pat_q;
  logic [LenW-1:0] hl, tl;

  state_e                      state_q, state_d;
  mode_e                       mode_q, mode_d;
  logic [FillW-1:0]            fill_q, fill_d;
  logic [HistLen-1:0][ByteW-1:0] hist_q, hist_d;
  logic [CrcW-1:0]             crc_q, crc_d;
  logic [ByteW-1:0]            byte_q, byte_d;
  event_e                      evt_q, evt_d;
  logic [FillW-1:0]            burst_len_q, burst_len_d;
  logic [FillW-1:0]            rd_idx_q, rd_idx_d;
  logic                        out_valid_q, out_valid_d;
  event_e                      out_event_q, out_event_d;
  logic [ByteW-1:0]            out_byte_q, out_byte_d;
  logic                        out_last_q, out_last_d;

  logic                        mem_we, mem_re;
  logic [AddrW-1:0]            mem_waddr;
  logic [ByteW-1:0]            mem_rdata;

  logic                          out_free;
  logic [FillW-1:0]              fill_n;
  logic [HistLen-1:0][ByteW-1:0] hist_n;
  logic [CrcW-1:0]               crc_n;
  logic                          head_miss, plain_hit, crc_hit, cust_hit;
  logic [FillW-1:0]              crc_len;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_len_q <= '0;
      head_pat_q <= '0;
      tail_len_q <= '0;
      tail_pat_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgHeadLength:  head_len_q <= cfg_data_i[LenW-1:0];
        CfgHeadPattern: head_pat_q <= cfg_data_i[PatW-1:0];
        CfgTailLength:  tail_len_q <= cfg_data_i[LenW-1:0];
        CfgTailPattern: tail_pat_q <= cfg_data_i[PatW-1:0];
        default: ;
      endcase
    end
  end

  assign hl = (head_len_q > LenW'(MaxMarkLen)) ? LenW'(MaxMarkLen) : head_len_q;
  assign tl = (tail_len_q > LenW'(MaxMarkLen)) ? LenW'(MaxMarkLen) : tail_len_q;

  hsfr_frame_store #(
    .Depth (BufferDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (byte_q),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Per-byte datapath: history shift, lagged CRC, header and tail compare
  always_comb begin
    logic [LenW-1:0] pidx;
    fill_n = fill_q + FillW'(1);
    hist_n = {hist_q[HistLen-2:0], byte_q};
    crc_n  = (fill_q >= FillW'(HistLen)) ? crc16_byte(crc_q, hist_q[HistLen-1]) : crc_q;

    head_miss = (fill_q < FillW'(hl)) && (byte_q != pat_byte(head_pat_q, fill_q[1:0]));

    plain_hit = (fill_n >= FillW'(3)) && (hist_n[0] == PlainTailByte)
             && (hist_n[1] == PlainTailByte) && (hist_n[2] == PlainTailByte);

    crc_hit = (fill_n >= FillW'(HistLen)) && (hist_n[3] == CrcTailFirst)
           && (hist_n[2] == CrcTailRest) && (hist_n[1] == CrcTailRest)
           && (hist_n[0] == CrcTailRest);
    crc_len = fill_n - FillW'(HistLen);

    cust_hit = (tl != '0) && (fill_n >= FillW'(tl));
    for (int j = 0; j < HistLen; j++) begin
      pidx = tl - LenW'(j) - LenW'(1);
      if ((LenW'(j) < tl) && (hist_n[j] != pat_byte(tail_pat_q, pidx[1:0]))) begin
        cust_hit = 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || out_if.ready;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    fill_d      = fill_q;
    hist_d      = hist_q;
    crc_d       = crc_q;
    byte_d      = byte_q;
    evt_d       = evt_q;
    burst_len_d = burst_len_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_event_d = out_event_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = fill_q[AddrW-1:0];

    case (state_q)
      StIn: begin
        if (in_if.valid) begin
          byte_d  = in_if.data_byte;
          state_d = StProc;
        end
      end

      StProc: begin
        state_d = StIn;
        case (mode_q)
          ModeInit: begin
            mode_d  = ModeIdle;
            evt_d   = EvReady;
            state_d = StEvt;
          end

          ModeHead, ModeRcv: begin
            if (fill_q >= FillW'(BufferDepth)) begin
              mode_d  = ModeError;
              evt_d   = EvOverflow;
              state_d = StEvt;
            end else begin
              mem_we = 1'b1;
              fill_d = fill_n;
              hist_d = hist_n;
              crc_d  = crc_n;
              rd_idx_d = '0;
              if (mode_q == ModeHead) begin
                if (head_miss) begin
                  mode_d = ModeIdle;
                end else if (fill_n >= FillW'(hl)) begin
                  fill_d = '0;
                  crc_d  = CrcInit;
                  mode_d = ModeRcv;
                end
              end else if (plain_hit) begin
                mode_d      = ModeIdle;
                burst_len_d = fill_n - FillW'(3);
                if (burst_len_d != '0) begin
                  state_d = StRead;
                end
              end else if (crc_hit) begin
                mode_d = ModeIdle;
                if ((crc_len >= FillW'(2)) && (crc_n == '0)) begin
                  if (crc_len == FillW'(2)) begin
                    evt_d   = EvEmpty;
                    state_d = StEvt;
                  end else begin
                    burst_len_d = crc_len - FillW'(2);
                    state_d     = StRead;
                  end
                end
              end else if (cust_hit) begin
                mode_d      = ModeIdle;
                burst_len_d = fill_n - FillW'(tl);
                if (burst_len_d != '0) begin
                  state_d = StRead;
                end
              end
            end
          end

          default: begin
            // start a new frame with this byte
            mem_we    = 1'b1;
            mem_waddr = '0;
            fill_d    = FillW'(1);
            hist_d    = hist_n;
            crc_d     = CrcInit;
            if (hl == '0) begin
              mode_d = ModeRcv;
            end else if (byte_q == pat_byte(head_pat_q, 2'd0)) begin
              mode_d = (hl == LenW'(1)) ? ModeRcv : ModeHead;
            end
          end
        endcase
      end

      StRead: begin
        mem_re  = 1'b1;
        state_d = StOut;
      end

      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_event_d = EvByte;
          out_byte_d  = mem_rdata;
          out_last_d  = (rd_idx_q + FillW'(1)) == burst_len_q;
          if (out_last_d) begin
            state_d = StIn;
          end else begin
            rd_idx_d = rd_idx_q + FillW'(1);
            state_d  = StRead;
          end
        end
      end

      StEvt: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_event_d = evt_q;
          out_byte_d  = '0;
          out_last_d  = 1'b1;
          state_d     = StIn;
        end
      end

      default: state_d = StIn;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIn;
      mode_q      <= ModeInit;
      fill_q      <= '0;
      hist_q      <= '0;
      crc_q       <= CrcInit;
      byte_q      <= '0;
      evt_q       <= EvReady;
      burst_len_q <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      out_event_q <= EvReady;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      fill_q      <= fill_d;
      hist_q      <= hist_d;
      crc_q       <= crc_d;
      byte_q      <= byte_d;
      evt_q       <= evt_d;
      burst_len_q <= burst_len_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      out_event_q <= out_event_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
    end
  end

  assign in_if.ready         = (state_q == StIn);
  assign out_if.valid        = out_valid_q;
  assign out_if.event_res    = out_event_q;
  assign out_if.payload_byte = out_byte_q;
  assign out_if.last         = out_last_q;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(BufferDepth))
    else $error("fill count beyond buffer depth");

  a_event_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && (out_if.event_res != EvByte)) |->
      (out_if.last && (out_if.payload_byte == '0)))
    else $error("event transaction not single or carries a byte");

  a_burst_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StRead) || (state_q == StOut)) |-> (rd_idx_q < burst_len_q))
    else $error("burst read index beyond burst length");

  a_accept_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> (state_q == StProc))
    else $error("accepted byte not processed");

  a_init_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeInit) |-> (fill_q == '0))
    else $error("frame data present before first byte");
`endif

endmodule

// File: tb/sv/hmi_serial_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// hmi_serial_frame_receiver_tb
// Drives serial bytes into the frame receiver under several header and tail
// settings. A scoreboard follows the deframing rules byte by byte, queues the
// results each byte should cause, and checks every result transaction against
// them. The run covers header matching, all three tails, CRC checks, empty
// frames, buffer overflow and back-pressure from a stalled receiver.
// ----------------------------------------------------------------------------
module hmi_serial_frame_receiver_tb;
  import hsfr_pkg::*;

  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 12;

  typedef enum logic [2:0] {
    RxInit  = 3'd0,
    RxIdle  = 3'd1,
    RxHead  = 3'd2,
    RxRcv   = 3'd3,
    RxError = 3'd4
  } rx_mode_e;

  typedef enum int unsigned {TailPlain, TailCrc, TailCustom, TailNone} tail_kind_e;

  typedef struct {
    event_e           ev;
    logic [ByteW-1:0] data;
    logic             last;
  } rx_result_t;

  class frame_scoreboard;
    rx_result_t       results_q[$];
    rx_mode_e         mode;
    logic [ByteW-1:0] store [BufferDepthDef];
    int unsigned      fill;
    logic [LenW-1:0]  head_len;
    logic [LenW-1:0]  tail_len;
    logic [PatW-1:0]  head_pat;
    logic [PatW-1:0]  tail_pat;
    int unsigned      fail_count;

    function new();
      mode       = RxInit;
      fill       = 0;
      head_len   = '0;
      tail_len   = '0;
      head_pat   = '0;
      tail_pat   = '0;
      fail_count = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    static function logic [CrcW-1:0] crc_of(input logic [ByteW-1:0] bytes_q[$]);
      logic [CrcW-1:0] crc;
      logic            lsb;
      crc = CrcInit;
      foreach (bytes_q[i]) begin
        crc[ByteW-1:0] = crc[ByteW-1:0] ^ bytes_q[i];
        repeat (8) begin
          lsb = crc[0];
          crc = crc >> 1;
          if (lsb) crc = crc ^ CrcPoly;
        end
      end
      return crc;
    endfunction

    function int unsigned mark_len(input logic [LenW-1:0] len);
      return (len > MaxMarkLenDef) ? MaxMarkLenDef : int'(len);
    endfunction

    function logic [ByteW-1:0] mark_byte(input logic [PatW-1:0] pat, input int unsigned idx);
      return 8'(pat >> (8 * (idx % 4)));
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
      case (idx)
        CfgHeadLength:  head_len = val[LenW-1:0];
        CfgHeadPattern: head_pat = val;
        CfgTailLength:  tail_len = val[LenW-1:0];
        CfgTailPattern: tail_pat = val;
        default: ;
      endcase
    endfunction

    function bit ends_with(input logic [ByteW-1:0] mark [4], input int unsigned n);
      if (fill < n) return 1'b0;
      for (int unsigned k = 0; k < n; k++) begin
        if (store[fill - n + k] != mark[k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void push(input event_e ev, input logic [ByteW-1:0] data, input logic last);
      rx_result_t r;
      r.ev   = ev;
      r.data = data;
      r.last = last;
      results_q.push_back(r);
    endfunction

    function void push_burst();
      for (int unsigned i = 0; i < fill; i++) push(EvByte, store[i], i + 1 == fill);
    endfunction

    function void note_byte(input logic [ByteW-1:0] b);
      int unsigned      hl;
      int unsigned      tl;
      int unsigned      k;
      logic [ByteW-1:0] mark [4];
      logic [ByteW-1:0] body_q[$];
      hl = mark_len(head_len);
      tl = mark_len(tail_len);

      if (mode == RxInit) begin
        mode = RxIdle;
        push(EvReady, '0, 1'b1);
        return;
      end

      if (mode == RxHead || mode == RxRcv) begin
        if (fill >= BufferDepthDef) begin
          mode = RxError;
          push(EvOverflow, '0, 1'b1);
          return;
        end
        store[fill] = b;
        fill++;
      end

      if (mode == RxHead) begin
        k = fill - 1;
        if (k < hl && b != mark_byte(head_pat, k)) begin
          mode = RxIdle;
          return;
        end
        if (fill >= hl) begin
          fill = 0;
          mode = RxRcv;
        end
        return;
      end

      if (mode == RxRcv) begin
        mark = '{PlainTailByte, PlainTailByte, PlainTailByte, 8'h00};
        if (ends_with(mark, 3)) begin
          fill -= 3;
          mode = RxIdle;
          push_burst();
          return;
        end
        mark = '{CrcTailFirst, CrcTailRest, CrcTailRest, CrcTailRest};
        if (ends_with(mark, 4)) begin
          fill -= 4;
          mode = RxIdle;
          for (k = 0; k < fill; k++) body_q.push_back(store[k]);
          if (fill < 2 || crc_of(body_q) != '0) return;
          fill -= 2;
          if (fill == 0) push(EvEmpty, '0, 1'b1);
          else push_burst();
          return;
        end
        if (tl > 0) begin
          for (k = 0; k < 4; k++) mark[k] = mark_byte(tail_pat, k);
          if (ends_with(mark, tl)) begin
            fill -= tl;
            mode = RxIdle;
            push_burst();
          end
        end
        return;
      end

      // idle or error: this byte opens a new frame
      store[0] = b;
      fill     = 1;
      if (hl == 0) mode = RxRcv;
      else if (b == mark_byte(head_pat, 0)) mode = (hl == 1) ? RxRcv : RxHead;
    endfunction

    function void check_result(input event_e ev, input logic [ByteW-1:0] data,
                               input logic last);
      rx_result_t e;
      if (results_q.size() == 0) begin
        $display("%0t: unexpected result event=%0d byte=%02h last=%0b",
                 $time, ev, data, last);
        fail_count++;
        return;
      end
      e = results_q.pop_front();
      if (e.ev != ev || e.data != data || e.last != last) begin
        $display("%0t: expected event=%0d byte=%02h last=%0b, actual event=%0d byte=%02h last=%0b",
                 $time, e.ev, e.data, e.last, ev, data, last);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return results_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic [15:0]         stall_mask;
  bit                  hold_request;
  int unsigned         burst_left;
  int unsigned         bytes_sent;
  frame_scoreboard     sb;

  hsfr_byte_if   byte_ch ();
  hsfr_result_if res_ch ();

  hmi_serial_frame_receiver DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (byte_ch),
    .out_if      (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    sb.note_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic settle();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic apply_regs(input logic [LenW-1:0] hl, input logic [PatW-1:0] hp,
                            input logic [LenW-1:0] tl, input logic [PatW-1:0] tp);
    put_reg(CfgHeadLength, CfgDataW'(hl));
    put_reg(CfgHeadPattern, hp);
    put_reg(CfgTailLength, CfgDataW'(tl));
    put_reg(CfgTailPattern, tp);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned n, input tail_kind_e kind,
                            input bit bad_head, input bit bad_crc);
    logic [ByteW-1:0] frame_q[$];
    logic [ByteW-1:0] crc_q[$];
    logic [CrcW-1:0]  crc;
    int unsigned      hl;
    int unsigned      tl;
    int unsigned      k;
    hl = sb.mark_len(sb.head_len);
    tl = sb.mark_len(sb.tail_len);
    for (k = 0; k < hl; k++) frame_q.push_back(sb.mark_byte(sb.head_pat, k));
    if (bad_head && hl > 0) begin
      k = $urandom_range(0, hl - 1);
      frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
    end
    // a one-byte header stays in the payload and so in the CRC
    if (hl == 1) crc_q.push_back(frame_q[0]);
    for (k = 0; k < n; k++) begin
      frame_q.push_back(8'($urandom));
      crc_q.push_back(frame_q[frame_q.size() - 1]);
    end
    case (kind)
      TailPlain: repeat (3) frame_q.push_back(PlainTailByte);
      TailCrc: begin
        crc = frame_scoreboard::crc_of(crc_q);
        if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(CrcTailFirst);
        repeat (3) frame_q.push_back(CrcTailRest);
      end
      TailCustom: for (k = 0; k < tl; k++) frame_q.push_back(sb.mark_byte(sb.tail_pat, k));
      default: ;
    endcase
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic random_frames(input int unsigned budget);
    int unsigned start;
    int unsigned n;
    int unsigned pick;
    tail_kind_e  kind;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (pick < 35) kind = TailPlain;
      else if (pick < 65) kind = TailCrc;
      else if (pick < 90) kind = (sb.mark_len(sb.tail_len) > 0) ? TailCustom : TailPlain;
      else begin
        kind = TailNone;
        n    = $urandom_range(1, 3);
      end
      send_frame(n, kind, $urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin : receiver
    int unsigned tick;
    int unsigned hold_left;
    tick      = 0;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= stall_mask[tick % 16];
      end
      tick++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      sb.check_result(res_ch.event_res, res_ch.payload_byte, res_ch.last);
    end
  end

  initial begin : stimulus
    sb = new();
    rst_ni            = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    cfg_we            = 1'b0;
    cfg_index         = CfgHeadLength;
    cfg_data          = '0;
    stall_mask        = 16'hFFFF;
    hold_request      = 1'b0;
    burst_left        = 0;
    bytes_sent        = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: no header, no custom tail
    send_byte(8'h00);
    send_byte(8'h00); send_byte(8'h80);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'hFF); send_byte(8'hFF);
    send_byte(CrcTailFirst); send_byte(CrcTailRest); send_byte(CrcTailRest);
    send_byte(CrcTailRest);
    send_byte(CrcTailFirst); send_byte(CrcTailRest); send_byte(CrcTailRest);
    send_byte(CrcTailRest);

    settle();
    apply_regs(3'd1, 32'h0000_00A5, 3'd7, 32'h1234_5678);
    send_byte(8'h00);
    send_byte(8'hA5); send_byte(8'h33);
    send_byte(8'h78); send_byte(8'h56); send_byte(8'h34); send_byte(8'h12);

    settle();
    apply_regs(3'd4, 32'hDEAD_BEEF, 3'd0, 32'h0);
    send_byte(8'hEF); send_byte(8'hBE); send_byte(8'h00);
    send_byte(8'hEF); send_byte(8'hBE);
    settle();
    put_reg(CfgHeadLength, CfgDataW'(3'd2));
    cfg_we <= 1'b0;
    send_byte(8'h55); send_byte(8'h11);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);

    settle();
    apply_regs(3'd0, $urandom, 3'd0, $urandom);
    send_frame(66, TailNone, 1'b0, 1'b0);
    random_frames(4);

    settle();
    apply_regs(3'd2, $urandom, 3'd2, $urandom);
    stall_mask = 16'($urandom) | 16'h0001;
    random_frames(1);
    hold_request = 1'b1;
    send_frame(12, TailPlain, 1'b0, 1'b0);
    send_frame(4, TailCrc, 1'b0, 1'b0);
    send_frame(2, TailCustom, 1'b0, 1'b0);
    random_frames(1);

    settle();
    apply_regs(3'd7, 32'hFFFF_FFFF, 3'd1, $urandom);
    stall_mask = 16'($urandom) | 16'h0001;
    random_frames(4);

    settle();
    apply_regs(3'd1, $urandom, 3'd4, 32'h0);
    stall_mask = 16'hFFFF;
    random_frames(4);

    settle();
    apply_regs(3'd3, $urandom, 3'd5, $urandom);
    stall_mask = 16'($urandom) | 16'h0001;
    random_frames(4);

    settle();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
sv/hsfr_pkg.sv
sv/hsfr_if.sv
sv/hsfr_frame_store.sv
sv/hmi_serial_frame_receiver.sv
tb/sv/hmi_serial_frame_receiver_tb.sv
